### design/umec_pkg.sv
// shared types and constants for the usb-midi event classifier
package umec_pkg;

  // sysex collection limit in bytes
  localparam int unsigned SysexDepth = 128;
  localparam logic [8:0] SYSEX_LIMIT = 9'(SysexDepth);

  // queue geometry
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);

  // midi byte codes
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END = 8'hF7;
  localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [7:0] ID_NON_RT = 8'h7E;
  localparam logic [7:0] ID_GEN_INFO = 8'h06;
  localparam logic [7:0] ID_REQUEST = 8'h01;
  localparam logic [7:0] ID_REPLY = 8'h02;
  localparam logic [7:0] ID_MFR = 8'h7D;
  localparam logic [7:0] REPLY_HEADER = 8'h04;
  localparam logic [2:0] REPLY_LAST_BEAT = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NOTE_ON = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_CODE = 3'd0;
  localparam logic [2:0] REG_FIRST_NOTE = 3'd1;
  localparam logic [2:0] REG_NOTE_SPAN = 3'd2;
  localparam logic [2:0] REG_SCALE_KIND = 3'd3;
  localparam logic [2:0] REG_POLYPHONY = 3'd4;
  localparam logic [2:0] REG_DELAY_MULT = 3'd5;
  localparam logic [2:0] REG_DELAY_UNIT = 3'd6;

  // command from front to back
  typedef enum logic [1:0] {
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_REPLY
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] key;
    logic [7:0] velocity;
  } entry_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [6:0] device_code;
    logic [6:0] first_note;
    logic [6:0] note_span;
    logic       scale_kind;
    logic [6:0] polyphony;
    logic [6:0] delay_multiplier;
    logic [6:0] delay_unit_ms;
  } cfg_t;

endpackage

### design/umec_front.sv
// front end: accepts packets, tracks sysex collection, issues commands
module umec_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           header,
  input  logic [7:0]           byte_a,
  input  logic [7:0]           byte_b,
  input  logic [7:0]           byte_c,
  output logic                 push,
  output umec_pkg::entry_t     push_entry
);

  logic       in_sysex, in_sysex_next;
  logic [7:0] sysex_count, sysex_count_next;
  logic [7:0] cap0, cap0_next;
  logic [7:0] cap1, cap1_next;
  logic [7:0] cap2, cap2_next;
  logic [8:0] count_sum;
  logic       done;
  logic       ident;

  // state update and command selection
  always_comb begin
    in_sysex_next = in_sysex;
    sysex_count_next = sysex_count;
    cap0_next = cap0;
    cap1_next = cap1;
    cap2_next = cap2;
    push = 1'b0;
    push_entry = '{cmd: umec_pkg::CMD_NOTE_OFF, key: byte_b, velocity: 8'd0};
    count_sum = {1'b0, sysex_count} + 9'd3;
    done = 1'b0;
    ident = 1'b0;
    if (accept && header != 8'd0) begin
      if (byte_a == umec_pkg::SYSEX_START) begin
        in_sysex_next = 1'b1;
        sysex_count_next = 8'd3;
        cap0_next = byte_b;
        cap1_next = 8'd0;
        cap2_next = 8'd0;
      end else if (in_sysex) begin
        // message positions 1, 3 and 4 are kept
        if (sysex_count == 8'd0) cap0_next = byte_b;
        if (sysex_count == 8'd1) cap0_next = byte_a;
        if (sysex_count == 8'd1) cap1_next = byte_c;
        if (sysex_count == 8'd2) cap1_next = byte_b;
        if (sysex_count == 8'd3) cap1_next = byte_a;
        if (sysex_count == 8'd2) cap2_next = byte_c;
        if (sysex_count == 8'd3) cap2_next = byte_b;
        if (sysex_count == 8'd4) cap2_next = byte_a;
        done = (byte_a == umec_pkg::SYSEX_END) || (byte_b == umec_pkg::SYSEX_END) ||
               (byte_c == umec_pkg::SYSEX_END) || (count_sum >= umec_pkg::SYSEX_LIMIT);
        ident = (cap0_next == umec_pkg::ID_NON_RT) && (cap1_next == umec_pkg::ID_GEN_INFO) &&
                (cap2_next == umec_pkg::ID_REQUEST);
        sysex_count_next = count_sum[8] ? 8'hFF : count_sum[7:0];
        if (done) begin
          in_sysex_next = 1'b0;
          sysex_count_next = 8'd0;
          if (ident) begin
            push = 1'b1;
            push_entry = '{cmd: umec_pkg::CMD_REPLY, key: 8'd0, velocity: 8'd0};
          end
        end
      end else begin
        case (byte_a[7:4])
          umec_pkg::STATUS_NOTE_ON: begin
            push = 1'b1;
            if (byte_c != 8'd0) begin
              push_entry = '{cmd: umec_pkg::CMD_NOTE_ON, key: byte_b, velocity: byte_c};
            end
          end
          umec_pkg::STATUS_NOTE_OFF: begin
            push = 1'b1;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  // sysex state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex <= 1'b0;
      sysex_count <= 8'd0;
      cap0 <= 8'd0;
      cap1 <= 8'd0;
      cap2 <= 8'd0;
    end else begin
      in_sysex <= in_sysex_next;
      sysex_count <= sysex_count_next;
      cap0 <= cap0_next;
      cap1 <= cap1_next;
      cap2 <= cap2_next;
    end
  end

endmodule

### design/umec_queue.sv
// short command queue between front and back ends
module umec_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  umec_pkg::entry_t     push_entry,
  input  logic                 pop,
  output umec_pkg::entry_t     head,
  output logic                 empty,
  output logic                 full
);

  umec_pkg::entry_t            store [umec_pkg::QueueDepth];
  logic [umec_pkg::QueueAw-1:0] wr_ptr;
  logic [umec_pkg::QueueAw-1:0] rd_ptr;
  logic [umec_pkg::QueueAw:0]   fill;
  logic                         do_push;
  logic                         do_pop;

  assign empty = (fill == '0);
  assign full = (fill == (umec_pkg::QueueAw + 1)'(umec_pkg::QueueDepth));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### design/umec_back.sv
// back end: turns commands into result items, five packets per reply
module umec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  umec_pkg::cfg_t       cfg,
  input  umec_pkg::entry_t     head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [7:0]           key,
  output logic [7:0]           velocity,
  output logic [7:0]           packet_code,
  output logic [7:0]           out_byte_a,
  output logic [7:0]           out_byte_b,
  output logic [7:0]           out_byte_c,
  output logic                 last
);

  logic [2:0]  beat;
  logic        load;
  logic [23:0] reply_bytes;

  assign load = !out_valid || !out_stall;
  assign pop = load && !empty &&
               (head.cmd != umec_pkg::CMD_REPLY || beat == umec_pkg::REPLY_LAST_BEAT);

  // reply packet bytes for the current beat
  always_comb begin
    case (beat)
      3'd0: reply_bytes = {umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, 1'b0, cfg.device_code};
      3'd1: reply_bytes = {umec_pkg::ID_GEN_INFO, umec_pkg::ID_REPLY, umec_pkg::ID_MFR};
      3'd2: reply_bytes = {umec_pkg::ID_MFR, 1'b0, cfg.first_note, 1'b0, cfg.note_span};
      3'd3: reply_bytes = {7'd0, cfg.scale_kind, 1'b0, cfg.polyphony,
                           1'b0, cfg.delay_multiplier};
      3'd4: reply_bytes = {1'b0, cfg.delay_unit_ms, umec_pkg::SYSEX_END, 8'd0};
      default: reply_bytes = 24'd0;
    endcase
  end

  // beat counter within a reply
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= 3'd0;
    end else if (load && !empty && head.cmd == umec_pkg::CMD_REPLY) begin
      beat <= (beat == umec_pkg::REPLY_LAST_BEAT) ? 3'd0 : beat + 3'd1;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      case (head.cmd)
        umec_pkg::CMD_NOTE_ON: begin
          kind <= umec_pkg::KIND_NOTE_ON;
          key <= head.key;
          velocity <= head.velocity;
          packet_code <= 8'd0;
          {out_byte_a, out_byte_b, out_byte_c} <= 24'd0;
          last <= 1'b1;
        end
        umec_pkg::CMD_NOTE_OFF: begin
          kind <= umec_pkg::KIND_NOTE_OFF;
          key <= head.key;
          velocity <= 8'd0;
          packet_code <= 8'd0;
          {out_byte_a, out_byte_b, out_byte_c} <= 24'd0;
          last <= 1'b1;
        end
        default: begin
          kind <= umec_pkg::KIND_REPLY;
          key <= 8'd0;
          velocity <= 8'd0;
          packet_code <= umec_pkg::REPLY_HEADER;
          {out_byte_a, out_byte_b, out_byte_c} <= reply_bytes;
          last <= (beat == umec_pkg::REPLY_LAST_BEAT);
        end
      endcase
    end
  end

endmodule

### design/usb_midi_event_classifier_top.sv
// top level of the usb-midi event classifier: config registers, front, queue, back
// path: an accepted packet's command is written into the queue, then moved into the
//   output register when that register is free
// throughput: one packet per cycle while the queue is not full; a note gives one result,
//   an identity reply gives five result packets, buffered by a four-entry queue
// reset: clears sysex state, empties the queue and output, loads config defaults
module usb_midi_event_classifier_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] header,
  input  logic [7:0] byte_a,
  input  logic [7:0] byte_b,
  input  logic [7:0] byte_c,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] key,
  output logic [7:0] velocity,
  output logic [7:0] packet_code,
  output logic [7:0] out_byte_a,
  output logic [7:0] out_byte_b,
  output logic [7:0] out_byte_c,
  output logic       last
);

  umec_pkg::cfg_t   cfg;
  umec_pkg::entry_t push_entry;
  umec_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  logic             accept;

  assign in_stall = full;
  assign accept = in_valid && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_code <= 7'd0;
      cfg.first_note <= 7'd55;
      cfg.note_span <= 7'd16;
      cfg.scale_kind <= 1'b0;
      cfg.polyphony <= 7'd1;
      cfg.delay_multiplier <= 7'd2;
      cfg.delay_unit_ms <= 7'd120;
    end else if (cfg_write) begin
      case (cfg_index)
        umec_pkg::REG_DEVICE_CODE: cfg.device_code <= cfg_data;
        umec_pkg::REG_FIRST_NOTE: cfg.first_note <= cfg_data;
        umec_pkg::REG_NOTE_SPAN: cfg.note_span <= cfg_data;
        umec_pkg::REG_SCALE_KIND: cfg.scale_kind <= cfg_data[0];
        umec_pkg::REG_POLYPHONY: cfg.polyphony <= cfg_data;
        umec_pkg::REG_DELAY_MULT: cfg.delay_multiplier <= cfg_data;
        umec_pkg::REG_DELAY_UNIT: cfg.delay_unit_ms <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  umec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .header     (header),
    .byte_a     (byte_a),
    .byte_b     (byte_b),
    .byte_c     (byte_c),
    .push       (push),
    .push_entry (push_entry)
  );

  umec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  umec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .key         (key),
    .velocity    (velocity),
    .packet_code (packet_code),
    .out_byte_a  (out_byte_a),
    .out_byte_b  (out_byte_b),
    .out_byte_c  (out_byte_c),
    .last        (last)
  );

endmodule

### tb/sv/usb_midi_event_classifier_top_test.sv
// self-checking testbench for the usb-midi event classifier top level
module usb_midi_event_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one result item as the block presents it
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key;
    logic [7:0] velocity;
    logic [7:0] packet_code;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic       last;
  } midi_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] header = '0;
  logic [7:0] byte_a = '0;
  logic [7:0] byte_b = '0;
  logic [7:0] byte_c = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] key;
  logic [7:0] velocity;
  logic [7:0] packet_code;
  logic [7:0] out_byte_a;
  logic [7:0] out_byte_b;
  logic [7:0] out_byte_c;
  logic       last;

  // mirror of the block's registers and sysex collection state
  umec_pkg::cfg_t dev_cfg;
  logic           sx_active;
  logic [7:0]     sx_count;
  logic [7:0]     sx_bytes [3];
  midi_result_t   results_due [$];

  // traffic shaping and bookkeeping
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int reply_packets = 0;
  int input_stall_cycles = 0;
  int settings_loaded = 0;

  usb_midi_event_classifier_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .header     (header),
    .byte_a     (byte_a),
    .byte_b     (byte_b),
    .byte_c     (byte_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .key        (key),
    .velocity   (velocity),
    .packet_code(packet_code),
    .out_byte_a (out_byte_a),
    .out_byte_b (out_byte_b),
    .out_byte_c (out_byte_c),
    .last       (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void push_result(logic [1:0] k, logic [7:0] n, logic [7:0] v,
                                      logic [7:0] code, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] c, logic fin);
    results_due.push_back('{k, n, v, code, a, b, c, fin});
  endfunction

  // predict what one accepted packet produces and advance the sysex state
  function automatic void classify_packet(logic [7:0] h, logic [7:0] a, logic [7:0] b,
                                          logic [7:0] c);
    int unsigned pos;
    int unsigned nxt;
    logic        done;
    logic [7:0]  trio [3];
    logic [7:0]  reply [15];
    if (h == 8'h00) return;
    // a start packet (re)opens collection and keeps its second byte
    if (a == umec_pkg::SYSEX_START) begin
      sx_active = 1'b1;
      sx_count = 8'd3;
      sx_bytes[0] = b;
      sx_bytes[1] = 8'h00;
      sx_bytes[2] = 8'h00;
      return;
    end
    // continuation: capture message positions 1, 3 and 4, no note decoding
    if (sx_active) begin
      trio[0] = a;
      trio[1] = b;
      trio[2] = c;
      pos = sx_count;
      nxt = pos + 3;
      for (int k = 0; k < 3; k++) begin
        case (pos + k)
          1: sx_bytes[0] = trio[k];
          3: sx_bytes[1] = trio[k];
          4: sx_bytes[2] = trio[k];
          default: ;
        endcase
      end
      done = (a == umec_pkg::SYSEX_END) || (b == umec_pkg::SYSEX_END) ||
             (c == umec_pkg::SYSEX_END) || (nxt >= umec_pkg::SysexDepth);
      sx_count = (nxt > 255) ? 8'd255 : 8'(nxt);
      if (done) begin
        sx_active = 1'b0;
        sx_count = 8'd0;
        if (sx_bytes[0] == umec_pkg::ID_NON_RT && sx_bytes[1] == umec_pkg::ID_GEN_INFO &&
            sx_bytes[2] == umec_pkg::ID_REQUEST) begin
          reply = '{umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT,
                    {1'b0, dev_cfg.device_code}, umec_pkg::ID_GEN_INFO,
                    umec_pkg::ID_REPLY, umec_pkg::ID_MFR, umec_pkg::ID_MFR,
                    {1'b0, dev_cfg.first_note},
                    {1'b0, dev_cfg.note_span}, {7'b0, dev_cfg.scale_kind},
                    {1'b0, dev_cfg.polyphony}, {1'b0, dev_cfg.delay_multiplier},
                    {1'b0, dev_cfg.delay_unit_ms}, umec_pkg::SYSEX_END, 8'h00};
          for (int p = 0; p < 5; p++)
            push_result(umec_pkg::KIND_REPLY, 8'h00, 8'h00, umec_pkg::REPLY_HEADER,
                        reply[3 * p], reply[3 * p + 1], reply[3 * p + 2], p == 4);
        end
      end
      return;
    end
    // channel messages: only note on and note off give a result
    if (a[7:4] == umec_pkg::STATUS_NOTE_ON) begin
      if (c != 8'h00) push_result(umec_pkg::KIND_NOTE_ON, b, c, '0, '0, '0, '0, 1'b1);
      else push_result(umec_pkg::KIND_NOTE_OFF, b, '0, '0, '0, '0, '0, 1'b1);
    end else if (a[7:4] == umec_pkg::STATUS_NOTE_OFF) begin
      push_result(umec_pkg::KIND_NOTE_OFF, b, '0, '0, '0, '0, '0, 1'b1);
    end
  endfunction

  function automatic void flag_mismatch(string why, midi_result_t want, midi_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, why);
      $display("  expected kind %0d key %h vel %h code %h bytes %h %h %h last %b",
               want.kind, want.key, want.velocity, want.packet_code, want.byte_a,
               want.byte_b, want.byte_c, want.last);
      $display("  actual   kind %0d key %h vel %h code %h bytes %h %h %h last %b",
               got.kind, got.key, got.velocity, got.packet_code, got.byte_a,
               got.byte_b, got.byte_c, got.last);
    end
  endfunction

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    midi_result_t got;
    midi_result_t want;
    if (!rst) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        got = {kind, key, velocity, packet_code, out_byte_a, out_byte_b, out_byte_c, last};
        if (results_due.size() == 0) begin
          flag_mismatch("result with nothing pending", '0, got);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (want.kind == umec_pkg::KIND_REPLY) reply_packets++;
          if (got !== want) flag_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] nz_header();
    return 8'($urandom_range(255, 1));
  endfunction

  // random data byte that neither opens nor closes a sysex message
  function automatic logic [7:0] rand_data();
    logic [7:0] v;
    do v = 8'($urandom_range(255));
    while (v == umec_pkg::SYSEX_START || v == umec_pkg::SYSEX_END);
    return v;
  endfunction

  // offer one item, with random idle cycles ahead of it, until accepted
  task automatic send_packet(input logic [7:0] h, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct);
    end
    header <= h;
    byte_a <= a;
    byte_b <= b;
    byte_c <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_accepted++;
    classify_packet(h, a, b, c);
  endtask

  // drop valid and wait until every predicted result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_setting(input logic [2:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      umec_pkg::REG_DEVICE_CODE: dev_cfg.device_code = val;
      umec_pkg::REG_FIRST_NOTE:  dev_cfg.first_note = val;
      umec_pkg::REG_NOTE_SPAN:   dev_cfg.note_span = val;
      umec_pkg::REG_SCALE_KIND:  dev_cfg.scale_kind = val[0];
      umec_pkg::REG_POLYPHONY:   dev_cfg.polyphony = val;
      umec_pkg::REG_DELAY_MULT:  dev_cfg.delay_multiplier = val;
      umec_pkg::REG_DELAY_UNIT:  dev_cfg.delay_unit_ms = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [6:0] dc, input logic [6:0] fn,
                               input logic [6:0] ns, input logic sk, input logic [6:0] pl,
                               input logic [6:0] dm, input logic [6:0] du);
    settle();
    write_setting(umec_pkg::REG_DEVICE_CODE, dc);
    write_setting(umec_pkg::REG_FIRST_NOTE, fn);
    write_setting(umec_pkg::REG_NOTE_SPAN, ns);
    write_setting(umec_pkg::REG_SCALE_KIND, {6'b0, sk});
    write_setting(umec_pkg::REG_POLYPHONY, pl);
    write_setting(umec_pkg::REG_DELAY_MULT, dm);
    write_setting(umec_pkg::REG_DELAY_UNIT, du);
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic load_random_settings();
    load_settings(7'($urandom_range(127)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), 1'($urandom_range(1)),
                  7'($urandom_range(127, 1)), 7'($urandom_range(127)),
                  7'($urandom_range(127)));
  endtask

  // closing packet with the end byte in a random slot
  task automatic send_sysex_tail();
    logic [7:0] t [3];
    t = '{rand_data(), rand_data(), rand_data()};
    t[$urandom_range(2)] = umec_pkg::SYSEX_END;
    send_packet(nz_header(), t[0], t[1], t[2]);
  endtask

  // well-formed identity request, ended in the second or third packet
  task automatic send_identity_request();
    send_packet(nz_header(), umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT,
                8'($urandom_range(255)));
    if ($urandom_range(1)) begin
      send_packet(nz_header(), umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST,
                  umec_pkg::SYSEX_END);
    end else begin
      send_packet(nz_header(), umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST, rand_data());
      send_sysex_tail();
    end
  endtask

  // reply built from the reset values of the registers
  task automatic test_reset_reply();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_packet(8'h04, umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, 8'h7F);
    send_packet(8'h07, umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST, umec_pkg::SYSEX_END);
    settle();
  endtask

  // note on and off at field extremes, ignored headers and other channel messages
  task automatic test_note_messages();
    send_packet(8'h00, 8'h90, 8'h40, 8'h40);
    send_packet(8'h09, 8'h90, 8'h00, 8'h01);
    send_packet(8'hFF, 8'h9F, 8'hFF, 8'hFF);
    send_packet(8'h01, 8'h95, 8'h3C, 8'h00);
    send_packet(8'h08, 8'h80, 8'hFF, 8'hFF);
    send_packet(8'h80, 8'h8F, 8'h00, 8'h00);
    send_packet(8'h0B, 8'hB0, 8'h07, 8'h7F);
    send_packet(8'h0C, 8'hC5, 8'h12, 8'h00);
    send_packet(8'h0E, 8'hEF, 8'h7F, 8'h7F);
    send_packet(8'h0F, 8'h7F, 8'hAA, 8'h55);
    send_packet(8'h0F, 8'hFF, 8'h55, 8'hAA);
    send_packet(8'h0F, 8'h00, 8'h00, 8'h00);
    send_packet(8'h0F, umec_pkg::SYSEX_END, 8'h01, 8'h02);
    settle();
  endtask

  // sysex corner cases: short, restarted, notes inside, header zero inside
  task automatic test_sysex_corners();
    sender_idle_pct = 19;
    stall_pct = 19;
    // short message leaves later positions at zero
    send_packet(8'h05, umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, umec_pkg::SYSEX_END);
    send_packet(8'h06, umec_pkg::SYSEX_END, 8'h00, 8'h00);
    // restart in the middle discards the earlier bytes
    send_packet(8'h04, umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, 8'h00);
    send_packet(8'h04, umec_pkg::SYSEX_START, 8'h11, 8'h22);
    send_packet(8'h07, umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST, umec_pkg::SYSEX_END);
    // a note packet inside sysex is data, not a note
    send_packet(8'h04, umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, 8'h00);
    send_packet(8'h09, 8'h90, 8'h40, 8'h40);
    send_packet(8'h05, umec_pkg::SYSEX_END, 8'h00, 8'h00);
    // header zero in the middle is ignored, end byte in the middle slot
    send_packet(8'h04, umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, 8'h01);
    send_packet(8'h00, umec_pkg::SYSEX_END, umec_pkg::SYSEX_END, umec_pkg::SYSEX_END);
    send_packet(8'h04, umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST, 8'h00);
    send_packet(8'h06, 8'h00, umec_pkg::SYSEX_END, 8'h00);
    // end byte inside the start packet does not close it
    send_packet(8'h04, umec_pkg::SYSEX_START, umec_pkg::SYSEX_END, umec_pkg::SYSEX_END);
    send_packet(8'h07, umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST, umec_pkg::SYSEX_END);
    // near miss on the request code
    send_packet(8'h04, umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, 8'h00);
    send_packet(8'h07, umec_pkg::ID_GEN_INFO, umec_pkg::ID_REPLY, umec_pkg::SYSEX_END);
    settle();
  endtask

  // identity request closed by the byte limit rather than an end byte
  task automatic test_sysex_depth_limit();
    sender_idle_pct = 19;
    stall_pct = 19;
    send_packet(nz_header(), umec_pkg::SYSEX_START, umec_pkg::ID_NON_RT, rand_data());
    send_packet(nz_header(), umec_pkg::ID_GEN_INFO, umec_pkg::ID_REQUEST, rand_data());
    repeat ((umec_pkg::SysexDepth - 6 + 2) / 3) send_packet(nz_header(), rand_data(),
                                                            rand_data(), rand_data());
    // collection is closed now, so this is a plain note
    send_packet(8'h09, 8'h90, 8'h24, 8'h10);
    settle();
  endtask

  // reply contents under minimum, maximum and random register settings
  task automatic test_register_settings();
    sender_idle_pct = 19;
    stall_pct = 19;
    load_settings(7'd0, 7'd0, 7'd0, 1'b0, 7'd1, 7'd0, 7'd0);
    send_identity_request();
    load_settings(7'd127, 7'd127, 7'd127, 1'b1, 7'd127, 7'd127, 7'd127);
    send_identity_request();
    repeat (2) begin
      load_random_settings();
      send_identity_request();
    end
    settle();
  endtask

  // mixed traffic: mostly well-formed notes and sysex, some noise
  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int sent;
    int pick;
    int body;
    logic [7:0] h;
    sender_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_packet(nz_header(),
                    {($urandom_range(1) ? umec_pkg::STATUS_NOTE_ON : umec_pkg::STATUS_NOTE_OFF),
                     4'($urandom_range(15))},
                    8'($urandom_range(255)),
                    ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
        sent += 1;
      end else if (pick < 60) begin
        send_identity_request();
        sent += 2;
      end else if (pick < 75) begin
        body = $urandom_range(3);
        send_packet(nz_header(), umec_pkg::SYSEX_START,
                    $urandom_range(1) ? umec_pkg::ID_NON_RT : 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        repeat (body) send_packet(nz_header(), rand_data(), rand_data(), rand_data());
        send_sysex_tail();
        sent += body + 2;
      end else begin
        h = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
        send_packet(h, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        if (h != 8'h00) sent += 1;
      end
    end
    settle();
  endtask

  // long receiver hold-off while replies keep coming, so the input stalls
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_request = 300;
    repeat (8) send_identity_request();
    repeat (6) send_packet(8'h09, 8'h91, 8'($urandom_range(255)), 8'($urandom_range(255)));
    settle();
  endtask

  initial begin
    dev_cfg = '{device_code: 7'd0, first_note: 7'd55, note_span: 7'd16, scale_kind: 1'b0,
                polyphony: 7'd1, delay_multiplier: 7'd2, delay_unit_ms: 7'd120};
    sx_active = 1'b0;
    sx_count = 8'd0;
    sx_bytes = '{8'h00, 8'h00, 8'h00};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_reply();
    test_note_messages();
    test_sysex_corners();
    test_sysex_depth_limit();
    test_register_settings();
    test_random_traffic(0, 0, 10);
    load_random_settings();
    test_random_traffic(78, 0, 10);
    load_random_settings();
    test_random_traffic(0, 78, 10);
    load_random_settings();
    test_random_traffic(19, 19, 10);
    test_backpressure();

    // drain with a limit, then leave room for stray results
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && results_due.size() != 0; n++) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d predicted results never arrived", results_due.size());
      mismatches += results_due.size();
    end
    repeat (20) @(posedge clk);

    $display("run covered %0d packets and %0d checked results, %0d of them reply packets",
             items_accepted, results_checked, reply_packets);
    $display("%0d register settings loaded, input held off for %0d cycles, %0d mismatches",
             settings_loaded, input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/umec_pkg.sv
design/umec_front.sv
design/umec_queue.sv
design/umec_back.sv
design/usb_midi_event_classifier_top.sv
tb/sv/usb_midi_event_classifier_top_test.sv
